[design/adf_pkg.sv]
// shared types, constants and the exponential table for the diffusion filter
package adf_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int VAL_W       = 8 + FRAC_BITS;
    localparam int COORD_W     = 6;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int DIM_MAX     = 64;
    localparam int EXP_ENTRIES = 256;
    localparam int EXP_IDX_W   = 8;
    localparam int COND_W      = 17;
    localparam int FLOW_W      = 36;
    localparam int LAM_W       = 15;
    localparam logic [LAM_W-1:0] LAMBDA_CAP = 15'd16384;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_ITER_COUNT   = 3'd2,
        CFG_STEP_SIZE    = 3'd3,
        CFG_INV_K_SQ     = 3'd4,
        CFG_EXP_COND     = 3'd5,
        CFG_GRAY_ONLY    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] pix_x;
        logic [COORD_W-1:0] pix_y;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [7:0]         alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } pix_out_t;

    typedef struct packed {
        logic [7:0]       alpha;
        logic [VAL_W-1:0] ch2;
        logic [VAL_W-1:0] ch1;
        logic [VAL_W-1:0] ch0;
    } pix_word_t;

    typedef struct packed {
        logic start_nb;
        logic first;
        logic start_upd;
    } lane_ctl_t;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_RD_C, SQ_LD_C, SQ_RD_N, SQ_LD_N, SQ_CALC, SQ_UPD, SQ_UPDW, SQ_WR
    } seq_state_t;

    typedef enum logic [3:0] {
        L_IDLE, L_SQ, L_MUL, L_R2, L_EXPT, L_EXPC, L_DSET, L_DIV, L_ACC, L_UPD1, L_UPD2
    } lane_state_t;

    typedef logic [COND_W-1:0] exp_tbl_t [EXP_ENTRIES];

    // shift and subtract quotient, only used while the table is elaborated
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b})
            begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^-f table, f = i / EXP_ENTRIES, from a truncated series of e^y
    function automatic exp_tbl_t build_exp_tbl();
        exp_tbl_t   tbl;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        for (int i = 0; i < EXP_ENTRIES; i++)
        begin
            y    = (64'(i) * LN2_Q32) >> EXP_IDX_W;
            term = 64'd1 << 32;
            sum  = term;
            for (int k = 1; k < 15; k++)
            begin
                term = udiv64((term * y) >> 32, 64'(k));
                sum  = sum + term;
            end
            q = udiv64((64'd1 << 48) + (sum >> 1), sum);
            tbl[i] = q[COND_W-1:0];
        end
        return tbl;
    endfunction

    localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

[design/adf_frame_mem.sv]
// one frame store: one write port, one registered read port
module adf_frame_mem
    import adf_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  pix_word_t         wdata,
    input  logic [ADDR_W-1:0] raddr,
    output pix_word_t         rdata
);

    pix_word_t mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/adf_lane.sv]
// one channel lane: conductance, flow accumulation and update of one value
module adf_lane
    import adf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctl_t        ctl,
    input  logic [VAL_W-1:0] center,
    input  logic [VAL_W-1:0] nb,
    input  logic [LAM_W-1:0] lam,
    input  logic [31:0]      ink,
    input  logic             exp_mode,
    output logic             done,
    output logic [VAL_W-1:0] new_val
);

    lane_state_t state_reg, state_next;

    logic signed [16:0]       d_reg;
    logic [31:0]              sq_reg;
    logic [47:0]              p_reg;
    logic [31:0]              lo_reg;
    logic [31:0]              r2_reg;
    logic [32:0]              t_reg;
    logic [COND_W-1:0]        c_reg;
    logic [32:0]              den_reg;
    logic [32:0]              rem_reg;
    logic [COND_W-1:0]        q_reg;
    logic [4:0]               cnt_reg;
    logic signed [FLOW_W-1:0] flow_reg;
    logic signed [51:0]       prod_reg;
    logic [VAL_W-1:0]         new_reg;

    logic signed [16:0] d_next;
    logic signed [33:0] sq_full;
    logic [47:0]        p_full;
    logic [47:0]        lo_full;
    logic [48:0]        r_sum;
    logic [31:0]        r2_next;
    logic [48:0]        t_full;
    logic [16:0]        n_val;
    logic [COND_W-1:0]  tbl_val;
    logic [17:0]        rnd_sum;
    logic [COND_W-1:0]  c_exp;
    logic [32:0]        den;
    logic [33:0]        num;
    logic [33:0]        rem2;
    logic               ge;
    logic [COND_W-1:0]  cval;
    logic signed [34:0] cd;
    logic signed [51:0] prod_full;
    logic signed [51:0] biased;
    logic signed [19:0] delta;
    logic signed [20:0] nv;

    assign d_next  = $signed({1'b0, nb}) - $signed({1'b0, center});
    assign sq_full = d_reg * d_reg;
    assign p_full  = sq_reg[31:16] * ink;
    assign lo_full = sq_reg[15:0] * ink;
    assign r_sum   = {1'b0, p_reg} + {17'b0, lo_reg};
    assign r2_next = (r_sum[48:40] != 9'd0) ? 32'hFFFF_FFFF : r_sum[39:8];
    assign t_full  = r2_reg * LOG2E_Q16;
    assign n_val   = t_reg[32:16];
    assign tbl_val = EXP_TBL[t_reg[15:8]];
    assign rnd_sum = {1'b0, tbl_val} + ((18'd1 << n_val[4:0]) >> 1);
    assign c_exp   = (n_val >= 17'd17) ? '0 : COND_W'(rnd_sum >> n_val[4:0]);
    assign den     = {1'b0, r2_reg} + 33'h1_0000;
    assign num     = 34'h1_0000_0000 + {2'b0, den[32:1]};
    assign rem2    = {rem_reg, q_reg[COND_W-1]};
    assign ge      = rem2 >= {1'b0, den_reg};
    assign cval    = exp_mode ? c_reg : q_reg;
    assign cd      = $signed({1'b0, cval}) * d_reg;
    assign prod_full = flow_reg * $signed({1'b0, lam});
    assign biased  = prod_reg + 52'sd2147483648;
    assign delta   = biased[51:32];
    assign nv      = $signed({5'b0, center}) + 21'(delta);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (ctl.start_nb)
                begin
                    state_next = L_SQ;
                end
                else if (ctl.start_upd)
                begin
                    state_next = L_UPD1;
                end
            end
            L_SQ:   state_next = L_MUL;
            L_MUL:  state_next = L_R2;
            L_R2:   state_next = exp_mode ? L_EXPT : L_DSET;
            L_EXPT: state_next = L_EXPC;
            L_EXPC: state_next = L_ACC;
            L_DSET: state_next = L_DIV;
            L_DIV:
            begin
                if (cnt_reg == 5'(COND_W - 1))
                begin
                    state_next = L_ACC;
                end
            end
            L_ACC:  state_next = L_IDLE;
            L_UPD1: state_next = L_UPD2;
            L_UPD2: state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        done    = (state_reg == L_IDLE);
        new_val = new_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && ctl.start_nb)
        begin
            d_reg <= d_next;
            if (ctl.first)
            begin
                flow_reg <= '0;
            end
        end
        if (state_reg == L_SQ)
        begin
            sq_reg <= sq_full[31:0];
        end
        if (state_reg == L_MUL)
        begin
            p_reg  <= p_full;
            lo_reg <= lo_full[47:16];
        end
        if (state_reg == L_R2)
        begin
            r2_reg <= r2_next;
        end
        if (state_reg == L_EXPT)
        begin
            t_reg <= t_full[48:16];
        end
        if (state_reg == L_EXPC)
        begin
            c_reg <= c_exp;
        end
        // restoring divide, rounded quotient of 2^32 by (2^16 + r2)
        if (state_reg == L_DSET)
        begin
            den_reg <= den;
            rem_reg <= {16'b0, num[33:17]};
            q_reg   <= num[16:0];
            cnt_reg <= '0;
        end
        if (state_reg == L_DIV)
        begin
            rem_reg <= ge ? 33'(rem2 - {1'b0, den_reg}) : rem2[32:0];
            q_reg   <= {q_reg[COND_W-2:0], ge};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (state_reg == L_ACC)
        begin
            flow_reg <= flow_reg + FLOW_W'(cd);
        end
        if (state_reg == L_UPD1)
        begin
            prod_reg <= prod_full;
        end
        if (state_reg == L_UPD2)
        begin
            if (nv < 0)
            begin
                new_reg <= '0;
            end
            else if (nv > 21'sd65535)
            begin
                new_reg <= '1;
            end
            else
            begin
                new_reg <= nv[VAL_W-1:0];
            end
        end
    end

endmodule

[design/adf_seq.sv]
// pass sequencer: walks the region, gathers neighbours and merges lane results
module adf_seq
    import adf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              run,
    input  logic [6:0]        frame_width,
    input  logic [6:0]        frame_height,
    input  logic [7:0]        iteration_count,
    input  logic              gray_only,
    input  pix_word_t         rdata_cur,
    input  logic [2:0]        lanes_done,
    input  logic [VAL_W-1:0]  lane_val [3],
    output logic              busy,
    output logic              sel,
    output logic [ADDR_W-1:0] raddr,
    output logic              we,
    output logic [ADDR_W-1:0] waddr,
    output pix_word_t         wdata,
    output pix_word_t         center,
    output lane_ctl_t         ctl
);

    seq_state_t state_reg, state_next;

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [1:0]         k_reg;
    logic [7:0]         iter_reg;
    logic               sel_reg;
    pix_word_t          center_reg;

    logic [6:0]         w;
    logic [6:0]         h;
    logic [7:0]         passes;
    logic               last_x;
    logic               last_y;
    logic               last_iter;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic               all_done;

    assign w = (frame_width == 7'd0) ? 7'd1 :
               (frame_width > 7'(DIM_MAX)) ? 7'(DIM_MAX) : frame_width;
    assign h = (frame_height == 7'd0) ? 7'd1 :
               (frame_height > 7'(DIM_MAX)) ? 7'(DIM_MAX) : frame_height;
    assign passes    = (iteration_count == 8'd0) ? 8'd1 : iteration_count;
    assign last_x    = ({1'b0, x_reg} + 7'd1) == w;
    assign last_y    = ({1'b0, y_reg} + 7'd1) == h;
    assign last_iter = (iter_reg + 8'd1) == passes;
    assign all_done  = &lanes_done;

    // neighbour order: up, down, right, left, clamped at the region edge
    always_comb
    begin
        nx = x_reg;
        ny = y_reg;
        case (k_reg)
            2'd0: ny = (y_reg != '0) ? y_reg - 1'b1 : y_reg;
            2'd1: ny = last_y ? y_reg : y_reg + 1'b1;
            2'd2: nx = last_x ? x_reg : x_reg + 1'b1;
            default: nx = (x_reg != '0) ? x_reg - 1'b1 : x_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE: if (run) state_next = SQ_RD_C;
            SQ_RD_C: state_next = SQ_LD_C;
            SQ_LD_C: state_next = SQ_RD_N;
            SQ_RD_N: state_next = SQ_LD_N;
            SQ_LD_N: state_next = SQ_CALC;
            SQ_CALC:
            begin
                if (all_done)
                begin
                    state_next = (k_reg == 2'd3) ? SQ_UPD : SQ_RD_N;
                end
            end
            SQ_UPD:  state_next = SQ_UPDW;
            SQ_UPDW: if (all_done) state_next = SQ_WR;
            SQ_WR:
            begin
                if (last_x && last_y && last_iter)
                begin
                    state_next = SQ_IDLE;
                end
                else
                begin
                    state_next = SQ_RD_C;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != SQ_IDLE);
        sel           = sel_reg;
        center        = center_reg;
        raddr         = {y_reg, x_reg};
        ctl.start_nb  = 1'b0;
        ctl.first     = 1'b0;
        ctl.start_upd = 1'b0;
        we            = 1'b0;
        waddr         = {y_reg, x_reg};
        wdata         = center_reg;
        unique case (state_reg)
            SQ_RD_N: raddr = {ny, nx};
            SQ_LD_N:
            begin
                ctl.start_nb = 1'b1;
                ctl.first    = (k_reg == 2'd0);
            end
            SQ_UPD:  ctl.start_upd = 1'b1;
            SQ_WR:
            begin
                we        = 1'b1;
                wdata.ch0 = lane_val[0];
                if (!gray_only)
                begin
                    wdata.ch1 = lane_val[1];
                    wdata.ch2 = lane_val[2];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            sel_reg   <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            k_reg     <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SQ_IDLE && run)
            begin
                x_reg    <= '0;
                y_reg    <= '0;
                iter_reg <= '0;
            end
            if (state_reg == SQ_LD_C)
            begin
                k_reg <= '0;
            end
            if (state_reg == SQ_CALC && all_done && k_reg != 2'd3)
            begin
                k_reg <= k_reg + 2'd1;
            end
            if (state_reg == SQ_WR)
            begin
                if (!last_x)
                begin
                    x_reg <= x_reg + 1'b1;
                end
                else
                begin
                    x_reg <= '0;
                    if (!last_y)
                    begin
                        y_reg <= y_reg + 1'b1;
                    end
                    else
                    begin
                        y_reg    <= '0;
                        sel_reg  <= ~sel_reg;
                        iter_reg <= iter_reg + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SQ_LD_C)
        begin
            center_reg <= rdata_cur;
        end
    end

    a_sel_flips_at_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != SQ_WR || !(last_x && last_y)) |=> $stable(sel_reg))
        else $error("frame select changed inside a pass");

    a_lanes_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start_nb || ctl.start_upd) |-> all_done)
        else $error("lane started while still working");

    a_coords_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != SQ_IDLE) |-> ({1'b0, x_reg} < w && {1'b0, y_reg} < h))
        else $error("pixel position outside active region");

endmodule

[design/anisotropic_diffusion_filter_top.sv]
// top level of the anisotropic diffusion filter: ports, registers and frame stores
//
// channel   direction  handshake           payload
// command   in         start & !busy       pixel_in (pix_in_t)
// result    out        result_valid strobe result (pix_out_t)
// config    in         cfg_we              cfg_index, cfg_data
//
// a pixel write goes into both stores at its transfer; a read result passes the store's
// read register and the result register; reads and writes may follow each other every
// cycle while busy is low; a run holds busy until its last pass is written, each lane
// finding conductance in its own unit, by the exponential table or by a quadratic divide
// reset clears control state and selects store a; frame contents are undefined until written
// results cannot be held off and are shown for exactly one cycle
module anisotropic_diffusion_filter_top
    import adf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pix_in_t               pixel_in,
    output logic                  result_valid,
    output pix_out_t              result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [6:0]       frame_width_reg;
    logic [6:0]       frame_height_reg;
    logic [7:0]       iteration_count_reg;
    logic [LAM_W-1:0] step_size_reg;
    logic [31:0]      inv_k_squared_reg;
    logic             exp_conductance_reg;
    logic             gray_only_reg;

    logic             rd_pend_reg;
    logic             result_valid_reg;
    pix_out_t         result_reg;

    logic              accept;
    logic              host_wr;
    logic              run;
    logic              seq_busy;
    logic              sel;
    logic [ADDR_W-1:0] seq_raddr;
    logic              seq_we;
    logic [ADDR_W-1:0] seq_waddr;
    pix_word_t         seq_wdata;
    pix_word_t         center;
    lane_ctl_t         ctl;
    logic [2:0]        lanes_done;
    logic [VAL_W-1:0]  lane_val [3];
    logic [VAL_W-1:0]  lane_center [3];
    logic [VAL_W-1:0]  lane_nb [3];
    logic [LAM_W-1:0]  lam;

    logic [ADDR_W-1:0] host_addr;
    pix_word_t         host_word;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    pix_word_t         wdata;
    logic              we_a;
    logic              we_b;
    pix_word_t         rdata_a;
    pix_word_t         rdata_b;
    pix_word_t         rdata_cur;

    assign accept  = start && !seq_busy;
    assign host_wr = accept && (pixel_in.kind == KIND_WRITE);
    assign run     = accept && (pixel_in.kind == KIND_RUN);
    assign busy    = seq_busy;
    assign lam     = (step_size_reg > LAMBDA_CAP) ? LAMBDA_CAP : step_size_reg;

    assign host_addr       = {pixel_in.pix_y, pixel_in.pix_x};
    assign host_word.alpha = pixel_in.alpha_in;
    assign host_word.ch0   = {pixel_in.red_in, FRAC_BITS'(0)};
    assign host_word.ch1   = {pixel_in.green_in, FRAC_BITS'(0)};
    assign host_word.ch2   = {pixel_in.blue_in, FRAC_BITS'(0)};

    // writes from outside go to both stores, a pass writes the one not current
    assign raddr     = seq_busy ? seq_raddr : host_addr;
    assign waddr     = seq_busy ? seq_waddr : host_addr;
    assign wdata     = seq_busy ? seq_wdata : host_word;
    assign we_a      = host_wr || (seq_we && sel);
    assign we_b      = host_wr || (seq_we && !sel);
    assign rdata_cur = sel ? rdata_b : rdata_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= 7'd64;
            frame_height_reg    <= 7'd64;
            iteration_count_reg <= 8'd10;
            step_size_reg       <= 15'd13107;
            inv_k_squared_reg   <= 32'd103205;
            exp_conductance_reg <= 1'b1;
            gray_only_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg     <= cfg_data[6:0];
                CFG_FRAME_HEIGHT: frame_height_reg    <= cfg_data[6:0];
                CFG_ITER_COUNT:   iteration_count_reg <= cfg_data[7:0];
                CFG_STEP_SIZE:    step_size_reg       <= cfg_data[LAM_W-1:0];
                CFG_INV_K_SQ:     inv_k_squared_reg   <= cfg_data;
                CFG_EXP_COND:     exp_conductance_reg <= cfg_data[0];
                CFG_GRAY_ONLY:    gray_only_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg      <= accept && (pixel_in.kind == KIND_READ);
            result_valid_reg <= rd_pend_reg;
        end
    end

    function automatic logic [7:0] round_sat(input logic [VAL_W-1:0] v);
        logic [VAL_W:0] s;
        s = {1'b0, v} + (VAL_W+1)'(1 << (FRAC_BITS - 1));
        return (s[VAL_W:FRAC_BITS] > 9'd255) ? 8'd255 : s[FRAC_BITS+7:FRAC_BITS];
    endfunction

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            result_reg.red_out   <= round_sat(rdata_cur.ch0);
            result_reg.green_out <= round_sat(rdata_cur.ch1);
            result_reg.blue_out  <= round_sat(rdata_cur.ch2);
            result_reg.alpha_out <= rdata_cur.alpha;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    adf_frame_mem u_mem_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    adf_frame_mem u_mem_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    adf_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .run             (run),
        .frame_width     (frame_width_reg),
        .frame_height    (frame_height_reg),
        .iteration_count (iteration_count_reg),
        .gray_only       (gray_only_reg),
        .rdata_cur       (rdata_cur),
        .lanes_done      (lanes_done),
        .lane_val        (lane_val),
        .busy            (seq_busy),
        .sel             (sel),
        .raddr           (seq_raddr),
        .we              (seq_we),
        .waddr           (seq_waddr),
        .wdata           (seq_wdata),
        .center          (center),
        .ctl             (ctl)
    );

    assign lane_center[0] = center.ch0;
    assign lane_center[1] = center.ch1;
    assign lane_center[2] = center.ch2;
    assign lane_nb[0]     = rdata_cur.ch0;
    assign lane_nb[1]     = rdata_cur.ch1;
    assign lane_nb[2]     = rdata_cur.ch2;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        adf_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .center   (lane_center[i]),
            .nb       (lane_nb[i]),
            .lam      (lam),
            .ink      (inv_k_squared_reg),
            .exp_mode (exp_conductance_reg),
            .done     (lanes_done[i]),
            .new_val  (lane_val[i])
        );
    end

endmodule

[tb/diffusion_checker.sv]
// checker for the diffusion filter: watches the ports, predicts read-backs and compares them
`timescale 1ns / 1ps

module diffusion_checker
    import adf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  pix_in_t               pixel_in,
    input  logic                  result_valid,
    input  pix_out_t              result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    reads_waiting
);

    int unsigned chan_val [2][4096][3];
    logic [7:0]  alpha_val [2][4096];
    bit          cur_sel;

    int unsigned width_reg, height_reg, passes_reg, lambda_reg, ik_reg;
    bit          exp_mode, gray_mode;

    longint unsigned pow2_frac [EXP_ENTRIES];
    pix_out_t        pending_reads [$];

    // 2^-f for f = i / 256 from the truncated e^y series
    initial
    begin
        longint unsigned y;
        longint unsigned term;
        longint unsigned sum;
        for (int i = 0; i < EXP_ENTRIES; i++)
        begin
            y    = (longint'(i) * 64'd2977044472) / EXP_ENTRIES;
            term = 64'd1 << 32;
            sum  = term;
            for (int k = 1; k < 15; k++)
            begin
                term = ((term * y) >> 32) / longint'(k);
                sum  = sum + term;
            end
            pow2_frac[i] = ((64'd1 << 48) + sum / 2) / sum;
        end
    end

    function automatic longint unsigned conductance(longint d);
        longint unsigned sq;
        longint unsigned p;
        longint unsigned lo;
        longint unsigned r2;
        longint unsigned t;
        longint unsigned n;
        longint unsigned idx;
        longint unsigned den;
        sq = longint'(d * d);
        p  = (sq >> 16) * longint'(ik_reg);
        lo = ((sq & 64'hFFFF) * longint'(ik_reg)) >> 16;
        r2 = (p + lo) >> 8;
        if (r2 > 64'hFFFF_FFFF)
            r2 = 64'hFFFF_FFFF;
        if (exp_mode)
        begin
            t = (r2 * 64'd94548) >> 16;
            n = t >> 16;
            if (n >= 17)
                return 0;
            idx = ((t & 64'hFFFF) * EXP_ENTRIES) >> 16;
            return (pow2_frac[idx] + ((64'd1 << n) >> 1)) >> n;
        end
        den = 64'd65536 + r2;
        return ((64'd1 << 32) + den / 2) / den;
    endfunction

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 1)
            return 1;
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

    function automatic void diffuse_region();
        int unsigned w;
        int unsigned h;
        int unsigned passes;
        int unsigned nch;
        int unsigned at;
        int unsigned nb [4];
        bit          nx;
        longint      c0;
        longint      flow;
        longint      d;
        longint      nv;
        w      = clamp_dim(width_reg);
        h      = clamp_dim(height_reg);
        passes = (passes_reg == 0) ? 1 : passes_reg;
        nch    = gray_mode ? 1 : 3;
        for (int unsigned it = 0; it < passes; it++)
        begin
            nx = ~cur_sel;
            for (int unsigned y = 0; y < h; y++)
            begin
                for (int unsigned x = 0; x < w; x++)
                begin
                    at    = y * 64 + x;
                    nb[0] = ((y > 0) ? y - 1 : y) * 64 + x;
                    nb[1] = ((y + 1 < h) ? y + 1 : y) * 64 + x;
                    nb[2] = y * 64 + ((x + 1 < w) ? x + 1 : x);
                    nb[3] = y * 64 + ((x > 0) ? x - 1 : x);
                    alpha_val[nx][at] = alpha_val[cur_sel][at];
                    for (int c = 0; c < 3; c++)
                        chan_val[nx][at][c] = chan_val[cur_sel][at][c];
                    for (int c = 0; c < nch; c++)
                    begin
                        c0   = chan_val[cur_sel][at][c];
                        flow = 0;
                        for (int k = 0; k < 4; k++)
                        begin
                            d    = longint'(chan_val[cur_sel][nb[k]][c]) - c0;
                            flow = flow + longint'(conductance(d)) * d;
                        end
                        nv = c0 + ((flow * longint'(lambda_reg) + (64'sd1 <<< 31)) >>> 32);
                        if (nv < 0)
                            nv = 0;
                        if (nv > 65535)
                            nv = 65535;
                        chan_val[nx][at][c] = int'(nv);
                    end
                end
            end
            cur_sel = nx;
        end
    endfunction

    function automatic pix_out_t read_back(int unsigned at);
        pix_out_t    o;
        int unsigned v [3];
        for (int c = 0; c < 3; c++)
        begin
            v[c] = (chan_val[cur_sel][at][c] + 128) >> 8;
            if (v[c] > 255)
                v[c] = 255;
        end
        o.red_out   = v[0][7:0];
        o.green_out = v[1][7:0];
        o.blue_out  = v[2][7:0];
        o.alpha_out = alpha_val[cur_sel][at];
        return o;
    endfunction

    assign reads_waiting = pending_reads.size();

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t    want;
        int unsigned at;
        if (!rst_n)
        begin
            cur_sel    = 1'b0;
            width_reg  = 64;
            height_reg = 64;
            passes_reg = 10;
            lambda_reg = 13107;
            ik_reg     = 103205;
            exp_mode   = 1'b1;
            gray_mode  = 1'b0;
            fail_count = 0;
            pending_reads.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_reads.size() == 0)
                begin
                    $error("read-back with nothing outstanding: %h", result);
                    fail_count++;
                end
                else
                begin
                    want = pending_reads.pop_front();
                    if (result.red_out !== want.red_out)
                    begin
                        $error("red_out expected %0d got %0d", want.red_out, result.red_out);
                        fail_count++;
                    end
                    if (result.green_out !== want.green_out)
                    begin
                        $error("green_out expected %0d got %0d", want.green_out,
                               result.green_out);
                        fail_count++;
                    end
                    if (result.blue_out !== want.blue_out)
                    begin
                        $error("blue_out expected %0d got %0d", want.blue_out, result.blue_out);
                        fail_count++;
                    end
                    if (result.alpha_out !== want.alpha_out)
                    begin
                        $error("alpha_out expected %0d got %0d", want.alpha_out,
                               result.alpha_out);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FRAME_WIDTH:  width_reg  = cfg_data[6:0];
                    CFG_FRAME_HEIGHT: height_reg = cfg_data[6:0];
                    CFG_ITER_COUNT:   passes_reg = cfg_data[7:0];
                    CFG_STEP_SIZE:    lambda_reg = (cfg_data[14:0] > LAMBDA_CAP) ?
                                                   LAMBDA_CAP : cfg_data[14:0];
                    CFG_INV_K_SQ:     ik_reg     = cfg_data;
                    CFG_EXP_COND:     exp_mode   = cfg_data[0];
                    CFG_GRAY_ONLY:    gray_mode  = cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                at = {pixel_in.pix_y, pixel_in.pix_x};
                case (pixel_in.kind)
                    KIND_WRITE:
                    begin
                        for (int s = 0; s < 2; s++)
                        begin
                            chan_val[s][at][0] = {pixel_in.red_in, 8'd0};
                            chan_val[s][at][1] = {pixel_in.green_in, 8'd0};
                            chan_val[s][at][2] = {pixel_in.blue_in, 8'd0};
                            alpha_val[s][at]   = pixel_in.alpha_in;
                        end
                    end
                    KIND_RUN:  diffuse_region();
                    KIND_READ: pending_reads.push_back(read_back(at));
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/testbench.sv]
// top of the diffusion filter testbench: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import adf_pkg::*;

    localparam int STALL_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    pix_in_t               pixel_in;
    logic                  result_valid;
    pix_out_t              result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    reads_waiting;

    bit                    written [4096];
    int unsigned           written_list [$];
    int unsigned           cur_w, cur_h;
    int                    sent;
    bit                    calm;
    int                    quiet_cycles;

    anisotropic_diffusion_filter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_in     (pixel_in),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    diffusion_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel_in      (pixel_in),
        .result_valid  (result_valid),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .reads_waiting (reads_waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // stall watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // one command transfer, sometimes followed by a random gap unless calm is set
    task automatic issue(pix_in_t cmd);
        start    <= 1'b1;
        pixel_in <= cmd;
        do
            @(posedge clk);
        while (busy);
        sent++;
        if (cmd.kind == KIND_WRITE && !written[{cmd.pix_y, cmd.pix_x}])
        begin
            written[{cmd.pix_y, cmd.pix_x}] = 1'b1;
            written_list.push_back({cmd.pix_y, cmd.pix_x});
        end
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic write_pixel(int unsigned x, int unsigned y, logic [31:0] rgba);
        pix_in_t cmd;
        cmd.kind     = KIND_WRITE;
        cmd.pix_x    = x[5:0];
        cmd.pix_y    = y[5:0];
        {cmd.red_in, cmd.green_in, cmd.blue_in, cmd.alpha_in} = rgba;
        issue(cmd);
    endtask

    task automatic read_pixel();
        pix_in_t     cmd;
        int unsigned at;
        at           = written_list[$urandom_range(0, written_list.size() - 1)];
        cmd          = pix_in_t'($urandom);
        cmd.kind     = KIND_READ;
        cmd.pix_x    = at[5:0];
        cmd.pix_y    = at[11:6];
        issue(cmd);
    endtask

    // every pixel in the active region must hold data before a run
    task automatic run_filter();
        pix_in_t cmd;
        for (int unsigned y = 0; y < cur_h; y++)
            for (int unsigned x = 0; x < cur_w; x++)
                if (!written[y * 64 + x])
                    write_pixel(x, y, $urandom);
        cmd      = pix_in_t'($urandom);
        cmd.kind = KIND_RUN;
        issue(cmd);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (reads_waiting != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes, cleared by configure
    task automatic set_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_FRAME_WIDTH)
            cur_w = value[6:0];
        if (idx == CFG_FRAME_HEIGHT)
            cur_h = value[6:0];
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned passes,
                             int unsigned lambda, logic [31:0] ik, bit expc, bit gray);
        drain();
        set_reg(CFG_FRAME_WIDTH, w);
        set_reg(CFG_FRAME_HEIGHT, h);
        set_reg(CFG_ITER_COUNT, passes);
        set_reg(CFG_STEP_SIZE, lambda);
        set_reg(CFG_INV_K_SQ, ik);
        set_reg(CFG_EXP_COND, expc);
        set_reg(CFG_GRAY_ONLY, gray);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        pix_in_t     cmd;
        int unsigned pick;
        int unsigned x;
        int unsigned y;
        rst_n     = 1'b0;
        start     = 1'b0;
        pixel_in  = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sent      = 0;
        calm      = 1'b0;
        cur_w     = 64;
        cur_h     = 64;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme values, every kind, unknown kind
        configure(4, 4, 2, 16384, 32'd103205, 1'b1, 1'b0);
        write_pixel(0, 0, 32'hFFFF_FFFF);
        write_pixel(63, 63, 32'h0000_0000);
        write_pixel(1, 0, 32'h00FF_00AA);
        write_pixel(0, 1, 32'hFF00_FF55);
        read_pixel();
        read_pixel();
        cmd      = pix_in_t'('1);
        issue(cmd);
        cmd.kind = 2'd3;
        cmd.pix_x = '0;
        cmd.pix_y = '0;
        issue(cmd);
        run_filter();
        for (int i = 0; i < 4; i++)
            read_pixel();
        configure(1, 1, 200, 16384, 32'hFFFF_FFFF, 1'b0, 1'b1);
        run_filter();
        read_pixel();
        configure(64, 2, 1, 0, 32'd0, 1'b1, 1'b0);
        run_filter();
        read_pixel();
        configure(2, 64, 1, 16384, 32'd0, 1'b0, 1'b0);
        run_filter();
        read_pixel();
        configure(3, 3, 1, 16384, 32'h0100_0000, 1'b1, 1'b1);
        run_filter();
        for (int i = 0; i < 4; i++)
            read_pixel();

        // random phases, each with its own settings
        while (sent < 1850)
        begin
            configure($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 4),
                      ($urandom_range(0, 3) == 0) ? 16384 : $urandom_range(0, 16384),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400000),
                      $urandom_range(0, 1), $urandom_range(0, 1));
            for (int n = 0; n < 150 && sent < 1850; n++)
            begin
                calm = (sent > 1650);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 9);
                    y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 9);
                    write_pixel(x, y, $urandom);
                end
                else if (pick < 94)
                    read_pixel();
                else if (pick < 97)
                begin
                    cmd      = pix_in_t'($urandom);
                    cmd.kind = 2'd3;
                    issue(cmd);
                end
                else
                    run_filter();
            end
        end

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
design/adf_pkg.sv
design/adf_frame_mem.sv
design/adf_lane.sv
design/adf_seq.sv
design/anisotropic_diffusion_filter_top.sv
tb/diffusion_checker.sv
tb/testbench.sv
